// File: rtl/metp_pkg.sv
package metp_pkg;

    localparam int FRAC_BITS_DEF  = 28;
    localparam int COUNT_BITS_DEF = 16;
    localparam int LIMIT_W        = 16;
    localparam int IN_W           = 32;
    localparam int LEVEL_W        = 17;

    localparam logic REG_LIMIT = 1'b0;
    localparam logic REG_PRIOR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIOR,
        ST_ITER,
        ST_DIV,
        ST_OUT
    } state_t;

    // Status handed from a serial unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// File: rtl/metp_sermul.sv
// Unsigned shift-add multiplier, one multiplier bit per cycle
module metp_sermul #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic [2*W-1:0] prod,
    output metp_pkg::unit_stat_t stat
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg;
    logic [2*W-1:0] mcand_reg;
    logic [W-1:0]   mplier_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    // Add one shifted partial product per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {{W{1'b0}}, a};
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

    assign prod      = acc_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/metp_serdiv.sv
// Restoring divider, one quotient bit per cycle
module metp_serdiv #(
    parameter int NW = 32,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo,
    output metp_pkg::unit_stat_t stat
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    assign trial = {rem_reg[DW-1:0], q_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift in one numerator bit, subtract when it fits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                rem_reg <= diff;
                q_reg   <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quo       = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// File: rtl/mandelbrot_escape_time_pixel_core.sv
// Work per item: a skipped pixel goes straight to the output; the prior test runs 2 or 6
// products; each full iteration runs three bit-serial products of 4F+8 bits, and then a
// COUNT_BITS+17 bit level division follows. F = FRAC_BITS.
// Flow: one item at a time; the next is taken once the result sits in the
// output register.
// Reset: rst_n asynchronous, active low; limit 256, prior test enabled, no result held.
module mandelbrot_escape_time_pixel_core #(
    parameter int FRAC_BITS  = metp_pkg::FRAC_BITS_DEF,
    parameter int COUNT_BITS = metp_pkg::COUNT_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // c_real [31:0], c_imag [63:32]
    input  logic        s_tuser,   // skip_pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // iteration_count [15:0], level [32:16], zero fill
    output logic [1:0]  m_tuser    // by_prior_test [0], left_unwritten [1]
);

    // Signed word: holds any input point and values up to 32 in magnitude
    localparam int XW  = (FRAC_BITS + 6 > metp_pkg::IN_W + 1) ? FRAC_BITS + 6
                                                               : metp_pkg::IN_W + 1;
    // Prior test word: enough for q*q at 4F fraction bits
    localparam int TW  = 4 * FRAC_BITS + 8;
    localparam int LW  = COUNT_BITS + 17;
    localparam int CBW = (COUNT_BITS < metp_pkg::LIMIT_W) ? COUNT_BITS : metp_pkg::LIMIT_W;
    // With this many fraction bits every input lies inside the cardioid
    localparam logic BIG_FRAC = (FRAC_BITS >= 33);

    // Configuration
    logic [metp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         prior_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 16'd256;
            prior_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                metp_pkg::REG_LIMIT: limit_reg <= cfg_wdata;
                metp_pkg::REG_PRIOR: prior_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic [COUNT_BITS-1:0] limit;
    assign limit = COUNT_BITS'({{(COUNT_BITS){1'b0}}, limit_reg[CBW-1:0]});

    metp_pkg::state_t state_reg, state_next;
    logic [3:0] step_reg, step_next;

    logic signed [XW-1:0] cr_reg, ci_reg, x_reg, y_reg;
    logic [COUNT_BITS-1:0] n_reg;
    logic        hit_reg, skip_reg;
    logic [TW-1:0] t0_reg, t1_reg, t2_reg;
    logic signed [XW+1:0] x2_reg, y2_reg;

    // Shared multiplier
    logic            m_start;
    logic [TW-1:0]   m_a, m_b;
    logic [2*TW-1:0] m_prod;
    metp_pkg::unit_stat_t m_stat;

    metp_sermul #(.W(TW)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(m_start), .a(m_a), .b(m_b),
        .prod(m_prod), .stat(m_stat)
    );

    logic              d_start;
    logic [LW-1:0]     d_quo;
    metp_pkg::unit_stat_t d_stat;

    metp_serdiv #(.NW(LW), .DW(COUNT_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(d_start),
        .num({1'b0, n_reg, 16'd0}), .den(limit), .quo(d_quo), .stat(d_stat)
    );

    // Fixed constants in FRAC_BITS fixed point; QQ is 1/16 at 2*FRAC_BITS fraction bits
    localparam logic signed [XW-1:0] ONE     = XW'(1) <<< FRAC_BITS;
    localparam logic signed [XW-1:0] QUARTER = ONE >>> 2;
    localparam logic signed [XW-1:0] TWO     = ONE <<< 1;
    localparam logic signed [XW+1:0] FOUR    = (XW+2)'(1) <<< (FRAC_BITS + 2);
    localparam logic [TW-1:0]        QQ      = TW'(1) << (2 * FRAC_BITS - 4);

    function automatic logic [XW-1:0] absv(input logic signed [XW-1:0] v);
        absv = v[XW-1] ? XW'(-v) : XW'(v);
    endfunction

    logic signed [XW-1:0] dx, u;
    assign dx = cr_reg + ONE;
    assign u  = cr_reg - QUARTER;

    // Truncated product of magnitudes, F fraction bits
    logic [XW+1:0] mtrunc;
    assign mtrunc = (XW+2)'(m_prod >> FRAC_BITS);

    logic in_box;
    assign in_box = !(cr_reg < -ONE || cr_reg > (ONE >>> 1) || ci_reg > ONE || ci_reg < -ONE);

    logic bulb_box;
    assign bulb_box = absv(dx) <= XW'(QUARTER) && absv(ci_reg) <= XW'(QUARTER);

    // Bulb decision after the second product, cardioid decision after the sixth
    logic bulb_hit, card_hit;
    logic [TW-1:0] qa_sh, card_lhs, card_rhs;
    assign bulb_hit = BIG_FRAC || (bulb_box && (t1_reg + m_prod[TW-1:0] <= QQ));
    assign qa_sh    = TW'(m_prod[TW-1:0] << FRAC_BITS);
    assign card_lhs = u[XW-1] ? t2_reg : t2_reg + qa_sh;
    assign card_rhs = u[XW-1] ? (t1_reg << (2*FRAC_BITS-2)) + qa_sh
                              : (t1_reg << (2*FRAC_BITS-2));
    assign card_hit = card_lhs <= card_rhs;

    logic signed [XW+1:0] xy_s, sum_x, sum_y;
    logic mag_big, iter_stop;
    assign mag_big   = absv(x_reg) > XW'(TWO) || absv(y_reg) > XW'(TWO);
    assign iter_stop = (n_reg >= limit) || mag_big;

    // Saturation is unreachable: values stay below 16 in magnitude here
    always_comb
    begin
        xy_s  = (x_reg[XW-1] ^ y_reg[XW-1]) ? -$signed(mtrunc) : $signed(mtrunc);
        sum_y = (xy_s <<< 1) + ci_reg;
        sum_x = x2_reg - y2_reg + cr_reg;
    end

    // Result waits here so the next item can start
    logic        out_valid_reg;
    logic [39:0] out_data_reg;
    logic [1:0]  out_user_reg;
    logic        out_load;
    assign out_load = (state_reg == metp_pkg::ST_OUT) && (!out_valid_reg || m_tready);

    // Next state, step and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        m_start = 1'b0;
        m_a = '0;
        m_b = '0;
        unique case (state_reg)
            metp_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    if (s_tuser || (limit == '0 && !prior_reg))
                        state_next = metp_pkg::ST_OUT;
                    else if (prior_reg)
                        state_next = metp_pkg::ST_PRIOR;
                    else
                        state_next = metp_pkg::ST_ITER;
                end
            end
            metp_pkg::ST_PRIOR:
            begin
                if (!m_stat.busy && !m_stat.done)
                begin
                    m_start = 1'b1;
                    unique case (step_reg)
                        4'd0: begin m_a = TW'(absv(dx)); m_b = TW'(absv(dx)); end
                        4'd1: begin m_a = TW'(absv(ci_reg)); m_b = TW'(absv(ci_reg)); end
                        4'd2: begin m_a = TW'(absv(u)); m_b = TW'(absv(u)); end
                        4'd3: begin m_a = TW'(absv(ci_reg)); m_b = TW'(absv(ci_reg)); end
                        4'd4: begin m_a = t0_reg; m_b = t0_reg; end
                        default: begin m_a = t0_reg; m_b = TW'(absv(u)); end
                    endcase
                end
                if (m_stat.done)
                begin
                    step_next = step_reg + 1'b1;
                    if (step_reg == 4'd1)
                    begin
                        if (bulb_hit)
                            state_next = metp_pkg::ST_OUT;
                        else if (!in_box)
                        begin
                            state_next = metp_pkg::ST_ITER;
                            step_next  = '0;
                        end
                    end
                    if (step_reg == 4'd5)
                    begin
                        step_next  = '0;
                        state_next = card_hit ? metp_pkg::ST_OUT : metp_pkg::ST_ITER;
                    end
                end
            end
            metp_pkg::ST_ITER:
            begin
                if (!m_stat.busy && !m_stat.done)
                begin
                    if (step_reg == 4'd0 && iter_stop)
                        state_next = (limit == '0) ? metp_pkg::ST_OUT : metp_pkg::ST_DIV;
                    else
                    begin
                        m_start = 1'b1;
                        unique case (step_reg)
                            4'd0: begin m_a = TW'(absv(x_reg)); m_b = TW'(absv(x_reg)); end
                            4'd1: begin m_a = TW'(absv(y_reg)); m_b = TW'(absv(y_reg)); end
                            default: begin m_a = TW'(absv(x_reg)); m_b = TW'(absv(y_reg)); end
                        endcase
                    end
                end
                if (m_stat.done)
                begin
                    if (step_reg == 4'd1)
                    begin
                        if (x2_reg + $signed(mtrunc) > FOUR)
                            state_next = metp_pkg::ST_DIV;
                        step_next = 4'd2;
                    end
                    else if (step_reg == 4'd2)
                        step_next = '0;
                    else
                        step_next = 4'd1;
                end
            end
            metp_pkg::ST_DIV:
            begin
                if (d_stat.done)
                    state_next = metp_pkg::ST_OUT;
            end
            metp_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = metp_pkg::ST_IDLE;
            end
            default: state_next = metp_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= metp_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Pulse the divider start in the first division cycle
    logic div_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_go_reg <= 1'b0;
        else
            div_go_reg <= (state_next == metp_pkg::ST_DIV) && (state_reg != metp_pkg::ST_DIV);
    end
    assign d_start = div_go_reg;

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == metp_pkg::ST_IDLE && s_tvalid)
        begin
            cr_reg   <= XW'($signed(s_tdata[31:0]));
            ci_reg   <= XW'($signed(s_tdata[63:32]));
            x_reg    <= XW'($signed(s_tdata[31:0]));
            y_reg    <= XW'($signed(s_tdata[63:32]));
            skip_reg <= s_tuser;
            hit_reg  <= 1'b0;
            n_reg    <= '0;
        end
        if (state_reg == metp_pkg::ST_PRIOR && m_stat.done)
        begin
            unique case (step_reg)
                4'd0: t1_reg <= m_prod[TW-1:0];
                4'd1: if (bulb_hit) hit_reg <= 1'b1;
                4'd2: t0_reg <= m_prod[TW-1:0];
                4'd3: begin t0_reg <= t0_reg + m_prod[TW-1:0];
                            t1_reg <= m_prod[TW-1:0]; end
                4'd4: t2_reg <= m_prod[TW-1:0];
                default: if (card_hit) hit_reg <= 1'b1;
            endcase
        end
        if (state_reg == metp_pkg::ST_ITER && m_stat.done)
        begin
            unique case (step_reg)
                4'd0: x2_reg <= $signed(mtrunc);
                4'd1: y2_reg <= $signed(mtrunc);
                default:
                begin
                    x_reg <= XW'(sum_x);
                    y_reg <= XW'(sum_y);
                    n_reg <= n_reg + 1'b1;
                end
            endcase
        end
    end

    logic [metp_pkg::LEVEL_W-1:0] lvl;
    always_comb
    begin
        if (skip_reg || (limit == '0 && !hit_reg))
            lvl = '0;
        else if (hit_reg)
            lvl = 17'h10000;
        else
            lvl = d_quo[metp_pkg::LEVEL_W-1:0];
    end

    // Hold the result until taken; load the next one as it leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_user_reg  <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
            out_data_reg  <= {7'd0, lvl,
                (skip_reg ? 16'd0 : (hit_reg ? 16'(limit) : 16'(n_reg)))};
            out_user_reg  <= {skip_reg, hit_reg & !skip_reg};
        end
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    assign s_tready = (state_reg == metp_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// File: bench/pixel_checker.sv
`timescale 1ns / 1ps

module pixel_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [63:0] s_tdata,   // c_real [31:0], c_imag [63:32]
    input  logic        s_tuser,   // skip_pixel
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // iteration_count [15:0], level [32:16], zero fill
    input  logic [1:0]  m_tuser,   // by_prior_test [0], left_unwritten [1]
    output int          fail_count,
    output int          pending,
    output int          pixel_count,
    output int          bulb_hits
);

    localparam int F = metp_pkg::FRAC_BITS_DEF;
    localparam longint ONE = 64'sd1 <<< F;
    localparam longint TWO = 64'sd2 <<< F;
    localparam longint FOUR = 64'sd4 <<< F;

    typedef struct packed {
        logic [15:0] count;
        logic [16:0] level;
        logic        by_prior;
        logic        unwritten;
    } pixel_t;

    pixel_t      expected_pixels[$];
    logic [15:0] limit_q;
    logic        prior_q;

    function automatic logic [63:0] mag(input longint v);
        return v < 0 ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // fixed-point product, truncated toward zero
    function automatic longint mulq(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  m;
        p = {64'd0, mag(a)} * {64'd0, mag(b)};
        m = p[F+63:F];
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint add_sat(input longint a, input longint b);
        logic [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63])
            return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        return s[63:0];
    endfunction

    // exact period-2 bulb / main cardioid membership
    function automatic bit in_bulb_or_cardioid(input longint x, input longint y);
        longint      quarter;
        longint      dx;
        longint      u;
        logic [63:0] s;
        logic [255:0] a, b, q, lhs, rhs, t;
        quarter = ONE >>> 2;
        dx = x + ONE;
        if (mag(dx) <= 64'(quarter) && mag(y) <= 64'(quarter))
        begin
            s = mag(dx) * mag(dx) + mag(y) * mag(y);
            if (s <= 64'(quarter) * 64'(quarter))
                return 1'b1;
        end
        if (x < -ONE || x > (ONE >>> 1) || y > ONE || y < -ONE)
            return 1'b0;
        u = x - quarter;
        a = 256'(mag(u));
        b = 256'(mag(y));
        q = a * a + b * b;
        lhs = q * q;
        rhs = (b * b) << (2 * F - 2);
        t = (q * a) << F;
        if (u >= 0)
            lhs = lhs + t;
        else
            rhs = rhs + t;
        return lhs <= rhs;
    endfunction

    function automatic pixel_t escape_time(input logic [31:0] cr_bits,
                                           input logic [31:0] ci_bits,
                                           input logic skip);
        pixel_t  r;
        longint  cr, ci, x, y, x2, y2, xy;
        int      n;
        logic [47:0] scaled;
        cr = longint'(signed'(cr_bits));
        ci = longint'(signed'(ci_bits));
        r = '0;
        if (skip)
        begin
            r.unwritten = 1'b1;
            return r;
        end
        if (prior_q && in_bulb_or_cardioid(cr, ci))
        begin
            r.count = limit_q;
            r.level = 17'd65536;
            r.by_prior = 1'b1;
            return r;
        end
        x = cr;
        y = ci;
        n = 0;
        while (n < int'(limit_q))
        begin
            if (mag(x) > 64'(TWO) || mag(y) > 64'(TWO))
                break;
            x2 = mulq(x, x);
            y2 = mulq(y, y);
            if (x2 + y2 > FOUR)
                break;
            xy = mulq(x, y);
            y = add_sat(add_sat(xy, xy), ci);
            x = add_sat(x2 - y2, cr);
            n++;
        end
        r.count = n[15:0];
        scaled = (48'(n) << 16) / (limit_q == 0 ? 48'd1 : 48'(limit_q));
        r.level = limit_q == 0 ? 17'd0 : scaled[16:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want, got;
        if (!rst_n)
        begin
            limit_q = 16'd256;
            prior_q = 1'b1;
            expected_pixels.delete();
            fail_count = 0;
            pending = 0;
            pixel_count = 0;
            bulb_hits = 0;
        end
        else
        begin
            // track register writes
            if (cfg_we)
            begin
                if (cfg_index == metp_pkg::REG_LIMIT)
                    limit_q = cfg_wdata;
                else
                    prior_q = cfg_wdata[0];
            end
            // predict on each accepted item
            if (s_tvalid && s_tready)
            begin
                want = escape_time(s_tdata[31:0], s_tdata[63:32], s_tuser);
                if (want.by_prior)
                    bulb_hits++;
                expected_pixels.push_back(want);
            end
            // compare each result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got.count = m_tdata[15:0];
                got.level = m_tdata[32:16];
                got.by_prior = m_tuser[0];
                got.unwritten = m_tuser[1];
                pixel_count++;
                if (expected_pixels.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: unexpected result count=%0d level=%0d",
                                 got.count, got.level);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (got !== want || m_tdata[39:33] !== 7'd0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"ERROR: pixel %0d exp cnt=%0d lvl=%0d bp=%b lu=%b,",
                                      " got cnt=%0d lvl=%0d bp=%b lu=%b"},
                                     pixel_count, want.count, want.level, want.by_prior,
                                     want.unwritten, got.count, got.level, got.by_prior,
                                     got.unwritten);
                    end
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = metp_pkg::REG_LIMIT;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // c_real [31:0], c_imag [63:32]
    logic        s_tuser = 1'b0; // skip_pixel
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;        // iteration_count [15:0], level [32:16], zero fill
    logic [1:0]  m_tuser;        // by_prior_test [0], left_unwritten [1]

    int fail_count, pending, pixel_count, bulb_hits;
    int send_idle = 18;
    int recv_idle = 49;
    int hold_cycles = 0;

    always #6 clk = ~clk;

    mandelbrot_escape_time_pixel_core u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    pixel_checker u_chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending),
        .pixel_count(pixel_count), .bulb_hits(bulb_hits)
    );

    // receiver: random stalls, or a long hold-off when asked
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            m_tready = 1'b0;
            hold_cycles = hold_cycles - 1;
        end
        else
            m_tready = ($urandom_range(99) >= recv_idle);
    end

    function automatic logic [31:0] fx(input real r);
        return 32'($rtoi(r * 268435456.0));
    endfunction

    // offer one pixel and hold it until taken
    task automatic send_pixel(input logic [31:0] cr, input logic [31:0] ci,
                              input logic skip);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {ci, cr};
        s_tuser = skip;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic send_random();
        logic [31:0] cr, ci;
        logic        sk;
        case ($urandom_range(9)) inside
            0, 1:
            begin
                cr = $urandom;
                ci = $urandom;
            end
            2, 3:
            begin
                // around the cardioid and bulb edges
                cr = 32'(int'($urandom_range(402653184)) - 335544320);
                ci = 32'(int'($urandom_range(402653184)) - 201326592);
            end
            default:
            begin
                // the usual viewing window
                cr = 32'(int'($urandom_range(939524096)) - 671088640);
                ci = 32'(int'($urandom_range(805306368)) - 402653184);
            end
        endcase
        sk = ($urandom_range(19) == 0);
        send_pixel(cr, ci, sk);
    endtask

    initial
    begin
        #400_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int mode;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed points at reset settings
        send_pixel(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_pixel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_pixel(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        send_pixel(32'h0000_0000, 32'h0000_0000, 1'b0);
        send_pixel(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pixel(fx(-1.0), fx(0.0), 1'b0);
        send_pixel(fx(-1.25), fx(0.0), 1'b0);
        send_pixel(fx(-0.75), fx(0.0), 1'b0);
        send_pixel(fx(0.25), fx(0.0), 1'b0);
        send_pixel(fx(0.2501), fx(0.0), 1'b0);
        send_pixel(fx(-1.2501), fx(0.0), 1'b0);
        send_pixel(fx(0.0), fx(1.0), 1'b0);
        send_pixel(fx(-2.0), fx(0.0), 1'b0);
        send_pixel(fx(0.3), fx(0.5), 1'b0);

        // prior test off: these points run the full loop
        write_reg(metp_pkg::REG_PRIOR, 16'd0);
        send_pixel(fx(0.0), fx(0.0), 1'b0);
        send_pixel(fx(-1.0), fx(0.0), 1'b0);
        send_pixel(fx(2.0), fx(2.0), 1'b0);
        send_pixel(fx(-0.75), fx(0.1), 1'b0);

        // largest limit: only cheap points
        write_reg(metp_pkg::REG_PRIOR, 16'd1);
        write_reg(metp_pkg::REG_LIMIT, 16'hFFFF);
        send_pixel(fx(-0.1), fx(0.1), 1'b0);
        send_pixel(fx(1.0), fx(1.0), 1'b0);
        send_pixel(fx(0.5), fx(0.5), 1'b0);
        send_pixel(fx(3.0), fx(-3.0), 1'b1);

        // zero limit and the smallest limit
        write_reg(metp_pkg::REG_LIMIT, 16'd0);
        send_pixel(fx(0.0), fx(0.0), 1'b0);
        send_pixel(fx(0.1), fx(0.9), 1'b0);
        write_reg(metp_pkg::REG_LIMIT, 16'd1);
        send_pixel(fx(0.1), fx(0.9), 1'b0);
        send_pixel(fx(-1.9), fx(0.0), 1'b0);

        // random phases: receiver-heavy idling, sender-heavy, then none
        for (mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 18 : (mode == 1) ? 49 : 0;
            recv_idle = (mode == 0) ? 49 : (mode == 1) ? 18 : 0;
            for (int i = 0; i < 240; i++)
            begin
                if (i % 40 == 0)
                begin
                    write_reg(metp_pkg::REG_PRIOR, 16'($urandom_range(1)));
                    write_reg(metp_pkg::REG_LIMIT,
                              (i == 80) ? 16'd64 : 16'($urandom_range(1, 8)));
                end
                if (i == 120)
                    hold_cycles = 12000;
                if (i == 200)
                    drain();
                send_random();
            end
        end

        drain();
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Covered %0d pixels (%0d decided by the bulb/cardioid test),", pixel_count,
                 bulb_hits);
        $display("limits from 0 to 65535, prior test on and off, stalls on both sides.");
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: mandelbrot_escape_time_pixel_core.f
rtl/metp_pkg.sv
rtl/metp_sermul.sv
rtl/metp_serdiv.sv
rtl/mandelbrot_escape_time_pixel_core.sv
bench/pixel_checker.sv
bench/tb.sv
